### design/vm_stack_frame_locals_unit_assert.svh
// Assertion macros for the stack, frame and locals unit.
// Depends on nothing; the asserting file supplies signals named clk and arst_n.
`ifndef VM_STACK_FRAME_LOCALS_UNIT_ASSERT_SVH
`define VM_STACK_FRAME_LOCALS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// An invariant that holds at every clock edge out of reset.
`define VMSF_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("vmsf invariant violated");
// A condition that implies another in the same cycle.
`define VMSF_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("vmsf implication violated");
// A condition that implies another in the following cycle.
`define VMSF_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("vmsf sequence violated");
`else
`define VMSF_ASSERT(name, expr)
`define VMSF_ASSERT_IMPL(name, pre, post)
`define VMSF_ASSERT_NEXT(name, pre, post)
`endif
`endif

### design/vmsf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the stack, frame and locals unit.
// Depends on nothing; used by the channel interfaces and the top level.
package vmsf_pkg;

	// Capacities of the three stores and the kept width of a value.
	localparam int STACK_DEPTH  = 256;
	localparam int FRAME_DEPTH  = 64;
	localparam int LOCALS_DEPTH = 256;
	localparam int VALUE_BITS   = 64;

	// Fixed widths of the item fields.
	localparam int OP_W     = 3;
	localparam int WORD_W   = 64;
	localparam int IDX_W    = 8;
	localparam int RP_W     = 32;
	localparam int FB_W     = 9;
	localparam int LB_OUT_W = 9;
	localparam int ST_W     = 3;

	// Widths that follow from the capacities.
	localparam int SP_W  = $clog2(STACK_DEPTH + 1);
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int FD_W  = $clog2(FRAME_DEPTH + 1);
	localparam int FA_W  = $clog2(FRAME_DEPTH);
	localparam int LU_W  = $clog2(LOCALS_DEPTH + 1);
	localparam int LA_W  = $clog2(LOCALS_DEPTH);
	localparam int CMP_W = (SP_W > FB_W) ? SP_W : FB_W;
	localparam int SUM_W = ((LU_W > IDX_W) ? LU_W : IDX_W) + 1;
	localparam int FR_W  = RP_W + FB_W + LU_W;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH       = 3'd0,
		OP_POP        = 3'd1,
		OP_FRAME_PUSH = 3'd2,
		OP_FRAME_POP  = 3'd3,
		OP_STORE      = 3'd4,
		OP_LOAD       = 3'd5
	} op_e;

	typedef enum logic [ST_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_STACK_OVER  = 3'd1,
		STAT_STACK_UNDER = 3'd2,
		STAT_FRAME_OVER  = 3'd3,
		STAT_FRAME_UNDER = 3'd4,
		STAT_INVALID     = 3'd5,
		STAT_LOCAL_RANGE = 3'd6
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_FILL
	} state_e;

	// One call frame record as kept in the frame memory.
	typedef struct packed {
		logic [RP_W-1:0] rp;
		logic [FB_W-1:0] fb;
		logic [LU_W-1:0] lb;
	} frame_t;

endpackage

### design/vmsf_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response items.
// Depends on vmsf_pkg for the field widths.
interface vmsf_req_if;
	logic                          valid;
	logic                          ready;
	logic [vmsf_pkg::OP_W-1:0]     operation;
	logic [vmsf_pkg::WORD_W-1:0]   push_value;
	logic [vmsf_pkg::IDX_W-1:0]    local_index;
	logic [vmsf_pkg::RP_W-1:0]     return_pointer;
	logic [vmsf_pkg::FB_W-1:0]     base_of_frame;

	modport source (output valid, operation, push_value, local_index, return_pointer,
		base_of_frame, input ready);
	modport sink (input valid, operation, push_value, local_index, return_pointer,
		base_of_frame, output ready);
endinterface

interface vmsf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [vmsf_pkg::ST_W-1:0]     status;
	logic [vmsf_pkg::WORD_W-1:0]   read_value;
	logic [vmsf_pkg::RP_W-1:0]     popped_return_pointer;
	logic [vmsf_pkg::FB_W-1:0]     popped_frame_base;
	logic [vmsf_pkg::LB_OUT_W-1:0] popped_locals_base;

	modport source (output valid, status, read_value, popped_return_pointer,
		popped_frame_base, popped_locals_base, input ready);
	modport sink (input valid, status, read_value, popped_return_pointer,
		popped_frame_base, popped_locals_base, output ready);
endinterface

### design/vmsf_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module vmsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/vm_stack_frame_locals_unit.sv
`timescale 1ns / 1ps
// Top level of the stack, frame and locals unit: control, depth counters, output register.
// Depends on vmsf_pkg, vmsf_chan_if, vmsf_ram and vm_stack_frame_locals_unit_assert.svh.
//
// Operand stack, call-frame stack and locals store of a stack machine, each in its own RAM
// with a registered read. One item is worked at a time and gives one response item. Push,
// frame push, local store and every rejected item load the output register on acceptance;
// pop and local load pass the RAM read register and a read state first. A frame pop that
// leaves frames open also passes a fill state, as the new top frame is reloaded from the
// frame RAM into the register copy that every frame check uses. The next item is accepted
// in the cycle that the waiting response leaves the output register, or at once when it is
// empty; a stalled response sink holds the input. Locals read as zero until written through
// one flag per slot that reset clears, so there is no clearing pass after reset.
`include "vm_stack_frame_locals_unit_assert.svh"

module vm_stack_frame_locals_unit (
	input  logic       clk,
	input  logic       arst_n,
	vmsf_req_if.sink   req,
	vmsf_rsp_if.source rsp
);

	vmsf_pkg::state_e state_q, state_d;

	logic [vmsf_pkg::SP_W-1:0]     opd_q;
	logic [vmsf_pkg::FD_W-1:0]     fd_q;
	logic [vmsf_pkg::LU_W-1:0]     lused_q;
	logic [vmsf_pkg::LOCALS_DEPTH-1:0] lvalid_q;
	vmsf_pkg::frame_t              top_q;
	logic                          rd_src_s1;
	logic                          lv_s1;

	logic                          rsp_valid_q;
	logic [vmsf_pkg::ST_W-1:0]     status_q;
	logic [vmsf_pkg::WORD_W-1:0]   rdval_q;
	logic [vmsf_pkg::RP_W-1:0]     prp_q;
	logic [vmsf_pkg::FB_W-1:0]     pfb_q;
	logic [vmsf_pkg::LB_OUT_W-1:0] plb_q;

	vmsf_pkg::op_e                 op;
	vmsf_pkg::status_e             dec_status;
	logic                          accept;
	logic                          has_frame, frame_ok, fb_bad, stack_full, frames_full;
	logic [vmsf_pkg::LU_W-1:0]     lbase;
	logic [vmsf_pkg::SUM_W-1:0]    slot_sum;
	logic [vmsf_pkg::LA_W-1:0]     slot;
	logic                          slot_fits, slot_used;
	logic                          act_push, act_pop, act_fpush, act_fpop, act_store, act_load;
	logic                          load_now, load_rd;

	logic                          op_we, op_re, fr_we, fr_re, lc_we, lc_re;
	logic [vmsf_pkg::SA_W-1:0]     op_waddr, op_raddr;
	logic [vmsf_pkg::FA_W-1:0]     fr_waddr, fr_raddr;
	logic [vmsf_pkg::VALUE_BITS-1:0] op_rdata, lc_rdata, store_val;
	logic [vmsf_pkg::FR_W-1:0]     fr_rdata;
	vmsf_pkg::frame_t              new_frame;

	// Checks against the current top frame and the resolved local slot.
	always_comb begin
		op          = vmsf_pkg::op_e'(req.operation);
		accept      = req.valid && req.ready;
		has_frame   = (fd_q != '0);
		frame_ok    = !has_frame ||
			((vmsf_pkg::CMP_W'(top_q.fb) <= vmsf_pkg::CMP_W'(opd_q)) && (top_q.lb <= lused_q));
		fb_bad      = vmsf_pkg::CMP_W'(req.base_of_frame) > vmsf_pkg::CMP_W'(opd_q);
		stack_full  = opd_q >= vmsf_pkg::SP_W'(vmsf_pkg::STACK_DEPTH);
		frames_full = fd_q >= vmsf_pkg::FD_W'(vmsf_pkg::FRAME_DEPTH);
		lbase       = has_frame ? top_q.lb : '0;
		slot_sum    = vmsf_pkg::SUM_W'(lbase) + vmsf_pkg::SUM_W'(req.local_index);
		slot        = slot_sum[vmsf_pkg::LA_W-1:0];
		slot_fits   = slot_sum < vmsf_pkg::SUM_W'(vmsf_pkg::LOCALS_DEPTH);
		slot_used   = slot_sum < vmsf_pkg::SUM_W'(lused_q);
		store_val   = req.push_value[vmsf_pkg::VALUE_BITS-1:0];
		new_frame   = '{rp: req.return_pointer, fb: req.base_of_frame, lb: lused_q};
	end

	// Operation decode: status code and the one action, if any, that goes ahead.
	always_comb begin
		dec_status = vmsf_pkg::STAT_OK;
		act_push   = 1'b0;
		act_pop    = 1'b0;
		act_fpush  = 1'b0;
		act_fpop   = 1'b0;
		act_store  = 1'b0;
		act_load   = 1'b0;
		case (op)
			vmsf_pkg::OP_PUSH: begin
				if (stack_full) dec_status = vmsf_pkg::STAT_STACK_OVER;
				else act_push = 1'b1;
			end
			vmsf_pkg::OP_POP: begin
				if (opd_q == '0) dec_status = vmsf_pkg::STAT_STACK_UNDER;
				else act_pop = 1'b1;
			end
			vmsf_pkg::OP_FRAME_PUSH: begin
				if (!frame_ok || fb_bad) dec_status = vmsf_pkg::STAT_INVALID;
				else if (frames_full) dec_status = vmsf_pkg::STAT_FRAME_OVER;
				else act_fpush = 1'b1;
			end
			vmsf_pkg::OP_FRAME_POP: begin
				if (!frame_ok) dec_status = vmsf_pkg::STAT_INVALID;
				else if (!has_frame) dec_status = vmsf_pkg::STAT_FRAME_UNDER;
				else act_fpop = 1'b1;
			end
			vmsf_pkg::OP_STORE: begin
				if (!frame_ok) dec_status = vmsf_pkg::STAT_INVALID;
				else if (!slot_fits) dec_status = vmsf_pkg::STAT_LOCAL_RANGE;
				else act_store = 1'b1;
			end
			vmsf_pkg::OP_LOAD: begin
				if (!frame_ok) dec_status = vmsf_pkg::STAT_INVALID;
				else if (!slot_fits || !slot_used) dec_status = vmsf_pkg::STAT_LOCAL_RANGE;
				else act_load = 1'b1;
			end
			default: dec_status = vmsf_pkg::STAT_INVALID;
		endcase
	end

	// Next state: wait for a RAM read, or reload the top frame after a frame pop that leaves frames open.
	always_comb begin
		state_d = state_q;
		case (state_q)
			vmsf_pkg::ST_IDLE: begin
				if (accept && (act_pop || act_load)) begin
					state_d = vmsf_pkg::ST_READ;
				end else if (accept && act_fpop && (fd_q > vmsf_pkg::FD_W'(1))) begin
					state_d = vmsf_pkg::ST_FILL;
				end
			end
			vmsf_pkg::ST_READ: state_d = vmsf_pkg::ST_IDLE;
			vmsf_pkg::ST_FILL: state_d = vmsf_pkg::ST_IDLE;
			default:           state_d = vmsf_pkg::ST_IDLE;
		endcase
	end

	// Handshake and RAM port controls.
	always_comb begin
		req.ready = (state_q == vmsf_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
		load_now  = accept && !(act_pop || act_load);
		load_rd   = (state_q == vmsf_pkg::ST_READ);
		op_we     = accept && act_push;
		op_waddr  = opd_q[vmsf_pkg::SA_W-1:0];
		op_re     = accept && act_pop;
		op_raddr  = vmsf_pkg::SA_W'(opd_q - vmsf_pkg::SP_W'(1));
		fr_we     = accept && act_fpush;
		fr_waddr  = fd_q[vmsf_pkg::FA_W-1:0];
		fr_re     = accept && act_fpop && (fd_q > vmsf_pkg::FD_W'(1));
		fr_raddr  = vmsf_pkg::FA_W'(fd_q - vmsf_pkg::FD_W'(2));
		lc_we     = accept && act_store;
		lc_re     = accept && act_load;
	end

	vmsf_ram #(.WIDTH(vmsf_pkg::VALUE_BITS), .DEPTH(vmsf_pkg::STACK_DEPTH)) u_operand_ram (
		.clk   (clk),
		.we    (op_we),
		.waddr (op_waddr),
		.wdata (store_val),
		.re    (op_re),
		.raddr (op_raddr),
		.rdata (op_rdata)
	);

	vmsf_ram #(.WIDTH(vmsf_pkg::FR_W), .DEPTH(vmsf_pkg::FRAME_DEPTH)) u_frame_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (new_frame),
		.re    (fr_re),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	vmsf_ram #(.WIDTH(vmsf_pkg::VALUE_BITS), .DEPTH(vmsf_pkg::LOCALS_DEPTH)) u_locals_ram (
		.clk   (clk),
		.we    (lc_we),
		.waddr (slot),
		.wdata (store_val),
		.re    (lc_re),
		.raddr (slot),
		.rdata (lc_rdata)
	);

	// State, depth counters, locals flags and the read source flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vmsf_pkg::ST_IDLE;
			opd_q     <= '0;
			fd_q      <= '0;
			lused_q   <= '0;
			lvalid_q  <= '0;
			rd_src_s1 <= 1'b0;
			lv_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (act_push) opd_q <= opd_q + vmsf_pkg::SP_W'(1);
				if (act_pop) opd_q <= opd_q - vmsf_pkg::SP_W'(1);
				if (act_fpush) fd_q <= fd_q + vmsf_pkg::FD_W'(1);
				if (act_fpop) fd_q <= fd_q - vmsf_pkg::FD_W'(1);
				if (act_store) begin
					lvalid_q[slot] <= 1'b1;
					if (!slot_used) lused_q <= vmsf_pkg::LU_W'(slot_sum) + vmsf_pkg::LU_W'(1);
				end
				rd_src_s1 <= act_load;
				lv_s1     <= lvalid_q[slot];
			end
		end
	end

	// The top frame copy holds meaning only while a frame is open.
	always_ff @(posedge clk) begin
		if (accept && act_fpush) begin
			top_q <= new_frame;
		end else if (state_q == vmsf_pkg::ST_FILL) begin
			top_q <= vmsf_pkg::frame_t'(fr_rdata);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_now || load_rd) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_now) begin
			status_q <= dec_status;
			rdval_q  <= '0;
			prp_q    <= act_fpop ? top_q.rp : '0;
			pfb_q    <= act_fpop ? top_q.fb : '0;
			plb_q    <= act_fpop ? vmsf_pkg::LB_OUT_W'(top_q.lb) : '0;
		end else if (load_rd) begin
			status_q <= vmsf_pkg::STAT_OK;
			if (rd_src_s1) begin
				rdval_q <= lv_s1 ? vmsf_pkg::WORD_W'(lc_rdata) : '0;
			end else begin
				rdval_q <= vmsf_pkg::WORD_W'(op_rdata);
			end
			prp_q <= '0;
			pfb_q <= '0;
			plb_q <= '0;
		end
	end

	assign rsp.valid                 = rsp_valid_q;
	assign rsp.status                = status_q;
	assign rsp.read_value            = rdval_q;
	assign rsp.popped_return_pointer = prp_q;
	assign rsp.popped_frame_base     = pfb_q;
	assign rsp.popped_locals_base    = plb_q;

	// Depths never pass the capacities.
	`VMSF_ASSERT(a_opd_range, opd_q <= vmsf_pkg::SP_W'(vmsf_pkg::STACK_DEPTH))
	`VMSF_ASSERT(a_lused_range, lused_q <= vmsf_pkg::LU_W'(vmsf_pkg::LOCALS_DEPTH))
	// The read state is always followed by a valid response in the next cycle.
	`VMSF_ASSERT_NEXT(a_read_resp, state_q == vmsf_pkg::ST_READ, rsp.valid)
	// A reload of the top frame only happens while frames remain open.
	`VMSF_ASSERT_IMPL(a_fill_frames, state_q == vmsf_pkg::ST_FILL, fd_q != '0)

endmodule
